// ----- src/les_pkg.sv -----
// Shared types and constants for the LED effect sequencer.
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

   localparam int NUM_LEDS   = 6;
   localparam int OUT_LEDS   = 6;
   localparam int LED_SEL_W  = $clog2(NUM_LEDS);
   localparam int LED_IDX_W  = $clog2(NUM_LEDS + 1);
   localparam int LEVEL_W    = 8;
   localparam int TIME_W     = 32;
   localparam int MS_CFG_W   = 10;
   localparam int MODE_W     = 2;
   localparam int PULSE_W    = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
   localparam logic [LEVEL_W-1:0] FADE_DELTA = 8'd15;

   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FADE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SWEEP = 2'd3;
   localparam logic [MODE_W-1:0] LAST_MODE  = MODE_SWEEP;

   localparam logic [MS_CFG_W-1:0] PRESS_GUARD_RST    = 10'd50;
   localparam logic [MS_CFG_W-1:0] SWEEP_INTERVAL_RST = 10'd100;

   // CSR map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_PRESS_GUARD    = 1'b0;
   localparam logic REG_SWEEP_INTERVAL = 1'b1;

   typedef struct packed {
      logic [MS_CFG_W-1:0] press_guard_ms;
      logic [MS_CFG_W-1:0] sweep_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic              button_level;
      logic [TIME_W-1:0] now_ms;
   } pass_type;

   typedef struct packed {
      logic [OUT_LEDS-1:0][LEVEL_W-1:0] level;
      logic [PULSE_W-1:0]               pulse_led;
      logic [MODE_W-1:0]                effect_mode;
   } result_type;

endpackage

`default_nettype wire

// ----- src/les_if.sv -----
// Valid/ready channel interfaces for pass requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface les_req_if;
   logic                      valid;
   logic                      ready;
   logic                      button_level;
   logic [les_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, button_level, now_ms, input ready);
   modport sink   (input valid, button_level, now_ms, output ready);
endinterface

interface les_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [les_pkg::LEVEL_W-1:0] level_0;
   logic [les_pkg::LEVEL_W-1:0] level_1;
   logic [les_pkg::LEVEL_W-1:0] level_2;
   logic [les_pkg::LEVEL_W-1:0] level_3;
   logic [les_pkg::LEVEL_W-1:0] level_4;
   logic [les_pkg::LEVEL_W-1:0] level_5;
   logic [les_pkg::PULSE_W-1:0] pulse_led;
   logic [les_pkg::MODE_W-1:0]  effect_mode;

   modport source (output valid, level_0, level_1, level_2, level_3, level_4, level_5,
                   pulse_led, effect_mode, input ready);
   modport sink   (input valid, level_0, level_1, level_2, level_3, level_4, level_5,
                   pulse_led, effect_mode, output ready);
endinterface

`default_nettype wire

// ----- src/les_csr.sv -----
// APB-style configuration registers for the LED effect sequencer.
`timescale 1ns / 1ps
`default_nettype none

module les_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [les_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [les_pkg::CSR_DATA_W-1:0]    pwdata,
   output      logic [les_pkg::CSR_DATA_W-1:0]    prdata,
   output      logic                              pready,
   output      les_pkg::cfg_type                  cfg
);

   logic [les_pkg::MS_CFG_W-1:0] press_guard_ff, press_guard_in;
   logic [les_pkg::MS_CFG_W-1:0] sweep_interval_ff, sweep_interval_in;
   logic                         wr_en;
   logic                         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      press_guard_in    = press_guard_ff;
      sweep_interval_in = sweep_interval_ff;
      if (wr_en) begin
         unique case (reg_sel)
            les_pkg::REG_PRESS_GUARD: begin
               press_guard_in = pwdata[les_pkg::MS_CFG_W-1:0];
            end
            les_pkg::REG_SWEEP_INTERVAL: begin
               sweep_interval_in = pwdata[les_pkg::MS_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         les_pkg::REG_PRESS_GUARD: begin
            prdata = les_pkg::CSR_DATA_W'(press_guard_ff);
         end
         les_pkg::REG_SWEEP_INTERVAL: begin
            prdata = les_pkg::CSR_DATA_W'(sweep_interval_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_guard_ff    <= les_pkg::PRESS_GUARD_RST;
         sweep_interval_ff <= les_pkg::SWEEP_INTERVAL_RST;
      end else begin
         press_guard_ff    <= press_guard_in;
         sweep_interval_ff <= sweep_interval_in;
      end
   end

   assign cfg.press_guard_ms    = press_guard_ff;
   assign cfg.sweep_interval_ms = sweep_interval_ff;

endmodule

`default_nettype wire

// ----- src/les_core.sv -----
// Effect state and the per-pass update: button check, then off/scan/fade/sweep.
`timescale 1ns / 1ps
`default_nettype none

module les_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire les_pkg::pass_type   pass_in,
   input  wire les_pkg::cfg_type    cfg,
   output      les_pkg::result_type result
);

   logic                           prev_button_ff, prev_button_in;
   logic [les_pkg::TIME_W-1:0]     last_press_ff, last_press_in;
   logic [les_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic                           off_applied_ff, off_applied_in;
   logic [les_pkg::LED_IDX_W-1:0]  scan_pos_ff, scan_pos_in;
   logic                           scan_down_ff, scan_down_in;
   logic [les_pkg::LEVEL_W-1:0]    fade_level_ff, fade_level_in;
   logic                           fade_down_ff, fade_down_in;
   logic [les_pkg::LED_SEL_W-1:0]  sweep_pos_ff, sweep_pos_in;
   logic                           sweep_back_ff, sweep_back_in;
   logic                           up_high_ff, up_high_in;
   logic                           down_high_ff, down_high_in;
   logic [les_pkg::TIME_W-1:0]     last_sweep_ff, last_sweep_in;
   logic [les_pkg::LEVEL_W-1:0]    level_ff [les_pkg::NUM_LEDS];
   logic [les_pkg::LEVEL_W-1:0]    level_in [les_pkg::NUM_LEDS];

   logic [les_pkg::TIME_W-1:0]     press_elapsed;
   logic [les_pkg::TIME_W-1:0]     sweep_elapsed;
   logic                           press_ok;
   logic                           sweep_go;
   logic [les_pkg::LED_IDX_W-1:0]  scan_cur;
   logic [les_pkg::LED_IDX_W-1:0]  scan_nxt;
   logic [les_pkg::LEVEL_W-1:0]    fade_nxt;
   logic [les_pkg::LED_IDX_W-1:0]  pulse;

   assign press_elapsed = pass_in.now_ms - last_press_ff;
   assign sweep_elapsed = pass_in.now_ms - last_sweep_ff;
   assign press_ok = pass_in.button_level && !prev_button_ff
                     && (press_elapsed > les_pkg::TIME_W'(cfg.press_guard_ms));
   assign sweep_go = sweep_elapsed > les_pkg::TIME_W'(cfg.sweep_interval_ms);

   // scan position is kept in range, but fold it as the wrap would
   assign scan_cur = (scan_pos_ff >= les_pkg::LED_IDX_W'(les_pkg::NUM_LEDS))
                     ? scan_pos_ff - les_pkg::LED_IDX_W'(les_pkg::NUM_LEDS) : scan_pos_ff;
   assign scan_nxt = scan_down_ff ? ((scan_cur == '0) ? '0 : scan_cur - 1'b1)
                                  : scan_cur + 1'b1;
   assign fade_nxt = fade_down_ff ? fade_level_ff - les_pkg::FADE_DELTA
                                  : fade_level_ff + les_pkg::FADE_DELTA;

   always_comb begin
      prev_button_in = pass_in.button_level;
      last_press_in  = last_press_ff;
      mode_in        = mode_ff;
      off_applied_in = off_applied_ff;
      scan_pos_in    = scan_pos_ff;
      scan_down_in   = scan_down_ff;
      fade_level_in  = fade_level_ff;
      fade_down_in   = fade_down_ff;
      sweep_pos_in   = sweep_pos_ff;
      sweep_back_in  = sweep_back_ff;
      up_high_in     = up_high_ff;
      down_high_in   = down_high_ff;
      last_sweep_in  = last_sweep_ff;
      level_in       = level_ff;
      pulse          = les_pkg::LED_IDX_W'(les_pkg::NUM_LEDS);

      if (press_ok) begin
         last_press_in  = pass_in.now_ms;
         mode_in        = (mode_ff == les_pkg::LAST_MODE) ? les_pkg::MODE_OFF : mode_ff + 1'b1;
         off_applied_in = 1'b0;
      end

      case (mode_in)
         les_pkg::MODE_OFF: begin
            if (!off_applied_in) begin
               for (int i = 0; i < les_pkg::NUM_LEDS; i++) begin
                  level_in[i] = '0;
               end
               off_applied_in = 1'b1;
            end
         end
         les_pkg::MODE_SCAN: begin
            level_in[scan_cur[les_pkg::LED_SEL_W-1:0]] = '0;
            pulse       = scan_cur;
            scan_pos_in = scan_nxt;
            if (scan_nxt >= les_pkg::LED_IDX_W'(les_pkg::NUM_LEDS - 1) || scan_nxt == '0) begin
               scan_down_in = !scan_down_ff;
            end
         end
         les_pkg::MODE_FADE: begin
            for (int i = 0; i < les_pkg::NUM_LEDS; i++) begin
               level_in[i] = fade_level_ff;
            end
            fade_level_in = fade_nxt;
            if (fade_nxt == les_pkg::LEVEL_MAX || fade_nxt == '0) begin
               fade_down_in = !fade_down_ff;
            end
         end
         default: begin
            if (sweep_go) begin
               last_sweep_in = pass_in.now_ms;
               if (!sweep_back_ff) begin
                  level_in[sweep_pos_ff] = up_high_ff ? les_pkg::LEVEL_MAX : '0;
                  if (sweep_pos_ff == les_pkg::LED_SEL_W'(les_pkg::NUM_LEDS - 1)) begin
                     if (!up_high_ff) begin
                        sweep_back_in = 1'b1;
                        up_high_in    = 1'b1;
                     end else begin
                        sweep_pos_in = '0;
                        up_high_in   = 1'b0;
                     end
                  end else begin
                     sweep_pos_in = sweep_pos_ff + 1'b1;
                  end
               end else begin
                  level_in[sweep_pos_ff] = down_high_ff ? les_pkg::LEVEL_MAX : '0;
                  if (sweep_pos_ff == '0) begin
                     if (!down_high_ff) begin
                        sweep_back_in = 1'b0;
                        down_high_in  = 1'b1;
                     end else begin
                        sweep_pos_in = les_pkg::LED_SEL_W'(les_pkg::NUM_LEDS - 1);
                        down_high_in = 1'b0;
                     end
                  end else begin
                     sweep_pos_in = sweep_pos_ff - 1'b1;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < les_pkg::OUT_LEDS; i++) begin
         result.level[i] = (i < les_pkg::NUM_LEDS) ? level_in[i] : '0;
      end
      result.pulse_led   = les_pkg::PULSE_W'(pulse);
      result.effect_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff <= 1'b0;
         last_press_ff  <= '0;
         mode_ff        <= les_pkg::MODE_OFF;
         off_applied_ff <= 1'b0;
         scan_pos_ff    <= '0;
         scan_down_ff   <= 1'b0;
         fade_level_ff  <= '0;
         fade_down_ff   <= 1'b0;
         sweep_pos_ff   <= '0;
         sweep_back_ff  <= 1'b0;
         up_high_ff     <= 1'b1;
         down_high_ff   <= 1'b1;
         last_sweep_ff  <= '0;
         for (int i = 0; i < les_pkg::NUM_LEDS; i++) begin
            level_ff[i] <= '0;
         end
      end else if (step) begin
         prev_button_ff <= prev_button_in;
         last_press_ff  <= last_press_in;
         mode_ff        <= mode_in;
         off_applied_ff <= off_applied_in;
         scan_pos_ff    <= scan_pos_in;
         scan_down_ff   <= scan_down_in;
         fade_level_ff  <= fade_level_in;
         fade_down_ff   <= fade_down_in;
         sweep_pos_ff   <= sweep_pos_in;
         sweep_back_ff  <= sweep_back_in;
         up_high_ff     <= up_high_in;
         down_high_ff   <= down_high_in;
         last_sweep_ff  <= last_sweep_in;
         level_ff       <= level_in;
      end
   end

   a_scan_pos_range: assert property (@(posedge clock) disable iff (reset)
      scan_pos_ff < les_pkg::LED_IDX_W'(les_pkg::NUM_LEDS))
      else $error("scan position out of range");

   a_sweep_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(sweep_pos_ff) < 32'(les_pkg::NUM_LEDS))
      else $error("sweep position out of range");

   // a press rearms the off clear unless the pass itself lands in off
   a_press_rearms_off: assert property (@(posedge clock) disable iff (reset)
      step && press_ok |=> (mode_ff == les_pkg::MODE_OFF) || !off_applied_ff)
      else $error("press did not rearm off clear");

endmodule

`default_nettype wire

// ----- src/led_effect_sequencer_top.sv -----
// Top level of the LED effect sequencer: channel registers, CSRs and effect core.
//
//   channel   dir   handshake              payload
//   req_bus   in    valid/ready            button_level, now_ms
//   rsp_bus   out   valid/ready            level_0..level_5, pulse_led, effect_mode
//   csr (APB) in    psel/penable, pready=1 paddr, pwdata, prdata
//
// One transaction per clock while rsp_bus.ready is high; each request passes through
// the input register, then the effect update into the result register.
// The input register refills while the result register is taken, so a full
// pipeline keeps moving as long as rsp_bus.ready is high.
// Synchronous active-high reset clears all effect state and both valid flags.
// When rsp_bus is stalled, the result register holds, and req_bus.ready drops once the input register is full.
`timescale 1ns / 1ps
`default_nettype none

module led_effect_sequencer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   les_req_if.sink                              req_bus,
   les_rsp_if.source                            rsp_bus,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [les_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [les_pkg::CSR_DATA_W-1:0]  pwdata,
   output      logic [les_pkg::CSR_DATA_W-1:0]  prdata,
   output      logic                            pready
);

   les_pkg::cfg_type    cfg;
   les_pkg::pass_type   in_data_ff, in_data_in;
   les_pkg::result_type out_data_ff, out_data_in;
   les_pkg::result_type core_result;
   logic                in_valid_ff, in_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_free;
   logic                step;
   logic                req_take;

   les_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   les_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .pass_in (in_data_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || step;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      if (req_take) begin
         in_data_in.button_level = req_bus.button_level;
         in_data_in.now_ms       = req_bus.now_ms;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_data_in  = core_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.level_0     = out_data_ff.level[0];
   assign rsp_bus.level_1     = out_data_ff.level[1];
   assign rsp_bus.level_2     = out_data_ff.level[2];
   assign rsp_bus.level_3     = out_data_ff.level[3];
   assign rsp_bus.level_4     = out_data_ff.level[4];
   assign rsp_bus.level_5     = out_data_ff.level[5];
   assign rsp_bus.pulse_led   = out_data_ff.pulse_led;
   assign rsp_bus.effect_mode = out_data_ff.effect_mode;

   a_step_fills_result: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed request did not produce a response");

endmodule

`default_nettype wire
